### hdl/lsp_pkg.sv
package lsp_pkg;

  localparam int unsigned NODES_DEF  = 8;
  localparam int unsigned NO_LINK    = 1000;
  localparam int unsigned NODE_W     = 3;
  localparam int unsigned COST_W     = 10;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [0:0] {
    CMD_WRITE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_e;

endpackage

### hdl/link_state_shortest_path.sv
// Link-state shortest path engine over a symmetric NODES x NODES cost matrix.
// Input stream: tuser[0] selects the command. A write transaction stores the
// link cost (capped at 1000) into both mirrored matrix entries and returns
// nothing; it holds the block until the mirror entry is written. A compute
// transaction runs the search from source_node (cfg_we_i/cfg_wdata_i, written
// while idle) and returns NODES result transactions, one per node in
// ascending order, the last one flagged by m_axis_tlast. A distance of 1000
// means unreachable. The search is one pass over the matrix row per round
// through a single add/compare unit fed by the cost RAM and the distance RAM,
// with at most NODES passes per compute; each result is then read back from
// the distance RAM before it is sent. s_axis_tready is high only while idle.
// Results wait in the output register while m_axis_tready is low; the block
// resumes when it is taken. Reset sets source_node to 0 and returns to idle;
// the cost matrix is not cleared and must be loaded before the first compute.
module link_state_shortest_path
#(
  parameter int unsigned NODES = lsp_pkg::NODES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsp_pkg::NODE_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [2:0] node_a, [5:3] node_b, [15:6] link_cost
  input  logic [lsp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] cmd
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] dest_node, [12:3] distance, [15:13] zero
  output logic [lsp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);

  import lsp_pkg::*;

  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned MW = $clog2(NODES * NODES);
  localparam logic [NW-1:0] LAST_IDX = NW'(NODES - 1);
  localparam logic [COST_W-1:0] INF = COST_W'(NO_LINK);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MIRROR = 7'b0000010,
    S_PASS   = 7'b0000100,
    S_DRAIN  = 7'b0001000,
    S_NEXT   = 7'b0010000,
    S_ORD    = 7'b0100000,
    S_OSEND  = 7'b1000000
  } state_e;

  function automatic logic [MW-1:0] mat_addr(input logic [NW-1:0] row,
                                             input logic [NW-1:0] col);
    mat_addr = MW'(row) * MW'(NODES) + MW'(col);
  endfunction

  state_e              state_q, state_d;
  logic [NODE_W-1:0]   src_q, src_d;
  logic [NODES-1:0]    visited_q, visited_d;
  logic                p_v_q, p_v_d;
  logic                found_q, found_d;
  logic                init_q, init_d;
  logic                m_valid_q, m_valid_d;
  logic [NW-1:0]       round_q, round_d;
  logic [NW-1:0]       j_q, j_d;
  logic [MW-1:0]       mw_addr_q, mw_addr_d;
  logic [COST_W-1:0]   mw_data_q, mw_data_d;
  logic [NW-1:0]       row_q, row_d;
  logic [COST_W-1:0]   best_q, best_d;
  logic [COST_W-1:0]   cand_best_q, cand_best_d;
  logic [NW-1:0]       pick_q, pick_d;
  logic [NW-1:0]       p_j_q, p_j_d;
  logic [COST_W-1:0]   out_dist_q, out_dist_d;

  logic [NODE_W-1:0]   in_a, in_b, src_mod;
  logic [COST_W-1:0]   in_cost_raw, in_cost;
  cmd_e                in_cmd;
  logic                in_ok, acc;
  logic [NW-1:0]       src_idx;

  logic                mat_we;
  logic [MW-1:0]       mat_waddr;
  logic [COST_W-1:0]   mat_wdata, mat_rdata;
  logic [COST_W-1:0]   dist_rdata;
  logic [NW-1:0]       dist_raddr;

  logic                p_unvis, p_wr, p_better;
  logic [COST_W:0]     p_sum;
  logic [COST_W-1:0]   p_via, p_new;
  logic [NODES-1:0]    src_onehot;

  assign in_cmd      = cmd_e'(s_axis_tuser[0]);
  assign in_a        = s_axis_tdata[2:0];
  assign in_b        = s_axis_tdata[5:3];
  assign in_cost_raw = s_axis_tdata[15:6];
  assign in_cost     = (in_cost_raw > INF) ? INF : in_cost_raw;
  assign in_ok       = (32'(in_a) < NODES) && (32'(in_b) < NODES);
  assign acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    src_mod = src_q;
    for (int k = 0; k < 8; k++) begin
      if (32'(src_mod) >= NODES) begin
        src_mod = src_mod - NODE_W'(NODES);
      end
    end
    src_idx = NW'(src_mod);
    src_onehot = '0;
    src_onehot[src_idx] = 1'b1;
  end

  always_comb begin
    mat_we    = 1'b0;
    mat_waddr = mat_addr(NW'(in_a), NW'(in_b));
    mat_wdata = in_cost;
    if (state_q == S_IDLE && acc && in_cmd == CMD_WRITE && in_ok) begin
      mat_we = 1'b1;
    end else if (state_q == S_MIRROR) begin
      mat_we    = 1'b1;
      mat_waddr = mw_addr_q;
      mat_wdata = mw_data_q;
    end
  end

  // while sending, fetch the node that follows the handshake
  assign dist_raddr = (state_q == S_OSEND) ? j_d : j_q;

  lsp_ram #(
    .WIDTH (COST_W),
    .DEPTH (NODES * NODES)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .raddr_i (mat_addr(row_q, j_q)),
    .rdata_o (mat_rdata)
  );

  lsp_ram #(
    .WIDTH (COST_W),
    .DEPTH (NODES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (p_v_q && p_wr),
    .waddr_i (p_j_q),
    .wdata_i (p_new),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  // shared relax/min unit
  always_comb begin
    p_unvis = !visited_q[p_j_q];
    p_sum   = {1'b0, best_q} + {1'b0, mat_rdata};
    p_via   = (p_sum > (COST_W + 1)'(NO_LINK)) ? INF : p_sum[COST_W-1:0];
    if (init_q) begin
      p_wr  = 1'b1;
      p_new = mat_rdata;
    end else begin
      p_wr  = p_unvis && (p_via < dist_rdata);
      p_new = p_wr ? p_via : dist_rdata;
    end
    p_better = p_unvis && (p_new < cand_best_q);
  end

  always_comb begin
    state_d     = state_q;
    src_d       = cfg_we_i ? cfg_wdata_i : src_q;
    visited_d   = visited_q;
    p_v_d       = 1'b0;
    p_j_d       = j_q;
    found_d     = found_q;
    init_d      = init_q;
    m_valid_d   = m_valid_q;
    round_d     = round_q;
    j_d         = j_q;
    mw_addr_d   = mw_addr_q;
    mw_data_d   = mw_data_q;
    row_d       = row_q;
    best_d      = best_q;
    cand_best_d = cand_best_q;
    pick_d      = pick_q;
    out_dist_d  = out_dist_q;

    if (p_v_q && p_better) begin
      cand_best_d = p_new;
      pick_d      = p_j_q;
      found_d     = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_cmd == CMD_COMPUTE) begin
            visited_d   = src_onehot;
            row_d       = src_idx;
            init_d      = 1'b1;
            round_d     = '0;
            j_d         = '0;
            cand_best_d = INF;
            found_d     = 1'b0;
            state_d     = S_PASS;
          end else if (in_ok) begin
            mw_addr_d = mat_addr(NW'(in_b), NW'(in_a));
            mw_data_d = in_cost;
            state_d   = S_MIRROR;
          end
        end
      end
      S_MIRROR: state_d = S_IDLE;
      S_PASS: begin
        p_v_d = 1'b1;
        j_d   = j_q + NW'(1);
        if (j_q == LAST_IDX) begin
          j_d     = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_NEXT;
      S_NEXT: begin
        j_d = '0;
        if (found_q && round_q != LAST_IDX) begin
          visited_d[pick_q] = 1'b1;
          best_d      = cand_best_q;
          row_d       = pick_q;
          round_d     = round_q + NW'(1);
          init_d      = 1'b0;
          cand_best_d = INF;
          found_d     = 1'b0;
          state_d     = S_PASS;
        end else begin
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        // dist RAM read of node j_q issued in the previous cycle
        out_dist_d = dist_rdata;
        m_valid_d  = 1'b1;
        state_d    = S_OSEND;
      end
      S_OSEND: begin
        if (m_axis_tready) begin
          m_valid_d = 1'b0;
          if (j_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + NW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      src_q     <= '0;
      visited_q <= '0;
      p_v_q     <= 1'b0;
      found_q   <= 1'b0;
      init_q    <= 1'b0;
      m_valid_q <= 1'b0;
      round_q   <= '0;
      j_q       <= '0;
    end else begin
      state_q   <= state_d;
      src_q     <= src_d;
      visited_q <= visited_d;
      p_v_q     <= p_v_d;
      found_q   <= found_d;
      init_q    <= init_d;
      m_valid_q <= m_valid_d;
      round_q   <= round_d;
      j_q       <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mw_addr_q   <= mw_addr_d;
    mw_data_q   <= mw_data_d;
    row_q       <= row_d;
    best_q      <= best_d;
    cand_best_q <= cand_best_d;
    pick_q      <= pick_d;
    p_j_q       <= p_j_d;
    out_dist_q  <= out_dist_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = (j_q == LAST_IDX);
  assign m_axis_tdata  = {(OUT_DATA_W - COST_W - NODE_W)'(0), out_dist_q, NODE_W'(j_q)};

  a_valid_in_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == S_OSEND)
    else $error("result valid outside send state");

  a_src_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_cmd == CMD_COMPUTE) |=> $onehot(visited_q))
    else $error("search did not start with only the source visited");

  a_dist_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_dist_q <= INF)
    else $error("distance above no-link cost");

  a_found_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && state_q == S_NEXT) |-> (cand_best_q < INF && !visited_q[pick_q]))
    else $error("picked node unreachable or already visited");

  a_pass_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_v_q |-> (state_q == S_PASS || state_q == S_DRAIN))
    else $error("relax unit active outside a pass");

endmodule

### hdl/lsp_ram.sv
module lsp_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
